@@ hw/rtl/fahb_pkg.sv @@
// fahb_pkg: shared types and constants of the four-axis histogram binner
// commands, status codes, register indexes and the lane/merge/accumulator records
// no dependencies
package fahb_pkg;

   localparam int NUM_AXES    = 4;
   localparam int AXIS_IDX_W  = 3;
   localparam int BIN_ADDR_W  = NUM_AXES * AXIS_IDX_W;
   localparam int BIN_DEPTH   = 1 << BIN_ADDR_W;
   localparam int BINS_REG_W  = 4;
   localparam int CMD_W       = 2;
   localparam int AXIS_SEL_W  = 2;
   localparam int SLOT_W      = 4;
   localparam int STATUS_W    = 2;
   localparam int WEIGHT_W    = 32;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;

   localparam logic [BINS_REG_W-1:0] BINS_RESET = 4'd8;

   localparam logic [CMD_W-1:0] CMD_LOAD_EDGE  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ADD_SAMPLE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ_BIN   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_NONE       = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_EDGE_LOADED   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_SAMPLE_COUNTED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_SAMPLE_DROPPED = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_BIN_READ      = 2'd3;

   localparam logic [1:0] REG_X_BINS = 2'd0;
   localparam logic [1:0] REG_Y_BINS = 2'd1;
   localparam logic [1:0] REG_Z_BINS = 2'd2;
   localparam logic [1:0] REG_E_BINS = 2'd3;

   typedef struct packed {
      logic                  hit;
      logic [AXIS_IDX_W-1:0] bin;
   } lane_result_type;

   typedef struct packed {
      logic                  hit;
      logic [BIN_ADDR_W-1:0] addr;
   } merge_result_type;

   typedef struct packed {
      logic                  valid;
      logic [BIN_ADDR_W-1:0] addr;
      logic [WEIGHT_W-1:0]   weight;
   } acc_op_type;

endpackage

@@ hw/rtl/four_axis_histogram_binner.sv @@
// four_axis_histogram_binner: top level of the four-axis weighted histogram
// request sequencer, edge tables, bin count registers, output register
// depends on fahb_pkg, fahb_axis_lane, fahb_merge, fahb_accum
//
//   channel   direction  handshake               payload
//   req_      in         req_valid / req_stall   command, edge load, sample, read address
//   rsp_      out        rsp_valid / rsp_stall   status, bin address, bin sum
//   apb       in         psel/penable/pready     bin counts x, y, z, energy
//
// a request passes through ST_EVAL, which bins all four axes in parallel lanes and issues
// the memory read, then ST_ACC, which adds and writes back while the next request enters
// after reset a clearing pass zeroes all 4096 entries of the bin memory; req_stall is high
// a stalled result holds the finishing request in the write-back cycle until taken
module four_axis_histogram_binner #(
   parameter int MAX_BINS_PER_AXIS = 8,
   parameter int COORD_WIDTH       = 32,
   parameter int SUM_WIDTH         = 48
) (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [fahb_pkg::CMD_W-1:0]            req_command,
   input  logic [fahb_pkg::AXIS_SEL_W-1:0]       req_axis_select,
   input  logic [fahb_pkg::SLOT_W-1:0]           req_edge_slot,
   input  logic signed [COORD_WIDTH-1:0]         req_edge_value,
   input  logic signed [COORD_WIDTH-1:0]         req_x_position,
   input  logic signed [COORD_WIDTH-1:0]         req_y_position,
   input  logic signed [COORD_WIDTH-1:0]         req_z_position,
   input  logic signed [COORD_WIDTH-1:0]         req_energy_value,
   input  logic [fahb_pkg::WEIGHT_W-1:0]         req_sample_weight,
   input  logic [fahb_pkg::BIN_ADDR_W-1:0]       req_read_address,

   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [fahb_pkg::STATUS_W-1:0]         rsp_status,
   output logic [fahb_pkg::BIN_ADDR_W-1:0]       rsp_bin_address,
   output logic [SUM_WIDTH-1:0]                  rsp_bin_sum,

   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [fahb_pkg::CSR_ADDR_W-1:0]       paddr,
   input  logic [fahb_pkg::CSR_DATA_W-1:0]       pwdata,
   output logic [fahb_pkg::CSR_DATA_W-1:0]       prdata,
   output logic                                  pready
);

   localparam int Edges = MAX_BINS_PER_AXIS + 1;
   localparam int Axes  = fahb_pkg::NUM_AXES;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EVAL = 2'd1;
   localparam logic [1:0] ST_ACC  = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   logic [fahb_pkg::CMD_W-1:0]      cmd_ff;
   logic [fahb_pkg::AXIS_SEL_W-1:0] axis_ff;
   logic [fahb_pkg::SLOT_W-1:0]     slot_ff;
   logic signed [COORD_WIDTH-1:0]   edge_val_ff;
   logic signed [COORD_WIDTH-1:0]   pos_ff [Axes];
   logic [fahb_pkg::WEIGHT_W-1:0]   weight_ff;
   logic [fahb_pkg::BIN_ADDR_W-1:0] read_addr_ff;

   logic signed [COORD_WIDTH-1:0]   edge_ff [Axes][Edges];
   logic [fahb_pkg::BINS_REG_W-1:0] bins_ff [Axes];

   logic [fahb_pkg::STATUS_W-1:0]   pend_status_ff;
   logic [fahb_pkg::BIN_ADDR_W-1:0] pend_addr_ff;

   logic                                  rsp_valid_ff;
   logic [fahb_pkg::STATUS_W-1:0]         rsp_status_ff;
   logic [fahb_pkg::BIN_ADDR_W-1:0]       rsp_addr_ff;
   logic [SUM_WIDTH-1:0]                  rsp_sum_ff;

   fahb_pkg::lane_result_type  lane_res [Axes];
   fahb_pkg::merge_result_type merged;
   fahb_pkg::acc_op_type       acc_op;

   logic [SUM_WIDTH-1:0] rd_sum;
   logic [SUM_WIDTH-1:0] add_sum;
   logic                 clearing;
   logic                 commit;
   logic                 req_accept;
   logic                 csr_write;

   // lanes and merge
   for (genvar a = 0; a < Axes; a++) begin : g_lane
      fahb_axis_lane #(
         .MAX_BINS_PER_AXIS (MAX_BINS_PER_AXIS),
         .COORD_WIDTH       (COORD_WIDTH)
      ) u_lane (
         .edges    (edge_ff[a]),
         .value    (pos_ff[a]),
         .bins_raw (bins_ff[a]),
         .result   (lane_res[a])
      );
   end

   fahb_merge u_merge (
      .lanes  (lane_res),
      .merged (merged)
   );

   always_comb begin
      acc_op.valid  = 1'b0;
      acc_op.addr   = merged.addr;
      acc_op.weight = weight_ff;
      if (state_ff == ST_EVAL) begin
         if (cmd_ff == fahb_pkg::CMD_READ_BIN) begin
            acc_op.valid = 1'b1;
            acc_op.addr  = read_addr_ff;
         end else if (cmd_ff == fahb_pkg::CMD_ADD_SAMPLE) begin
            acc_op.valid = merged.hit;
         end
      end
   end

   fahb_accum #(
      .SUM_WIDTH (SUM_WIDTH)
   ) u_accum (
      .clock      (clock),
      .reset      (reset),
      .op         (acc_op),
      .commit_add (commit && (pend_status_ff == fahb_pkg::STATUS_SAMPLE_COUNTED)),
      .rd_sum     (rd_sum),
      .add_sum    (add_sum),
      .clearing   (clearing)
   );

   // handshake and sequencing
   assign commit     = (state_ff == ST_ACC) && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = clearing || (state_ff == ST_EVAL) || ((state_ff == ST_ACC) && !commit);
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_command != fahb_pkg::CMD_NONE)) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (commit) begin
               if (req_accept && (req_command != fahb_pkg::CMD_NONE)) begin
                  state_in = ST_EVAL;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff       <= req_command;
         axis_ff      <= req_axis_select;
         slot_ff      <= req_edge_slot;
         edge_val_ff  <= req_edge_value;
         pos_ff[0]    <= req_x_position;
         pos_ff[1]    <= req_y_position;
         pos_ff[2]    <= req_z_position;
         pos_ff[3]    <= req_energy_value;
         weight_ff    <= req_sample_weight;
         read_addr_ff <= req_read_address;
      end
   end

   // edge table write and pending result
   always_ff @(posedge clock) begin
      if ((state_ff == ST_EVAL) && (cmd_ff == fahb_pkg::CMD_LOAD_EDGE)) begin
         for (int a = 0; a < Axes; a++) begin
            for (int j = 0; j < Edges; j++) begin
               if ((int'(axis_ff) == a) && (int'(slot_ff) == j)) begin
                  edge_ff[a][j] <= edge_val_ff;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_EVAL) begin
         unique case (cmd_ff)
            fahb_pkg::CMD_LOAD_EDGE: begin
               pend_status_ff <= fahb_pkg::STATUS_EDGE_LOADED;
               pend_addr_ff   <= '0;
            end
            fahb_pkg::CMD_ADD_SAMPLE: begin
               if (merged.hit) begin
                  pend_status_ff <= fahb_pkg::STATUS_SAMPLE_COUNTED;
                  pend_addr_ff   <= merged.addr;
               end else begin
                  pend_status_ff <= fahb_pkg::STATUS_SAMPLE_DROPPED;
                  pend_addr_ff   <= '0;
               end
            end
            fahb_pkg::CMD_READ_BIN: begin
               pend_status_ff <= fahb_pkg::STATUS_BIN_READ;
               pend_addr_ff   <= read_addr_ff;
            end
            fahb_pkg::CMD_NONE: begin
               pend_status_ff <= fahb_pkg::STATUS_SAMPLE_DROPPED;
               pend_addr_ff   <= '0;
            end
         endcase
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_status_ff <= pend_status_ff;
         rsp_addr_ff   <= pend_addr_ff;
         unique case (pend_status_ff)
            fahb_pkg::STATUS_SAMPLE_COUNTED: rsp_sum_ff <= add_sum;
            fahb_pkg::STATUS_BIN_READ:       rsp_sum_ff <= rd_sum;
            fahb_pkg::STATUS_EDGE_LOADED,
            fahb_pkg::STATUS_SAMPLE_DROPPED: rsp_sum_ff <= '0;
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_bin_address = rsp_addr_ff;
   assign rsp_bin_sum     = rsp_sum_ff;

   // bin count registers
   assign csr_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < Axes; a++) begin
            bins_ff[a] <= fahb_pkg::BINS_RESET;
         end
      end else if (csr_write) begin
         unique case (paddr[3:2])
            fahb_pkg::REG_X_BINS: bins_ff[0] <= pwdata[fahb_pkg::BINS_REG_W-1:0];
            fahb_pkg::REG_Y_BINS: bins_ff[1] <= pwdata[fahb_pkg::BINS_REG_W-1:0];
            fahb_pkg::REG_Z_BINS: bins_ff[2] <= pwdata[fahb_pkg::BINS_REG_W-1:0];
            fahb_pkg::REG_E_BINS: bins_ff[3] <= pwdata[fahb_pkg::BINS_REG_W-1:0];
         endcase
      end
   end

   assign prdata = fahb_pkg::CSR_DATA_W'(bins_ff[paddr[3:2]]);

endmodule

@@ hw/rtl/fahb_axis_lane.sv @@
// fahb_axis_lane: bin search of one axis against its edge table
// compares the value with every edge in parallel and picks the lowest matching bin
// depends on fahb_pkg
module fahb_axis_lane #(
   parameter int MAX_BINS_PER_AXIS = 8,
   parameter int COORD_WIDTH       = 32
) (
   input  logic signed [COORD_WIDTH-1:0]        edges [MAX_BINS_PER_AXIS+1],
   input  logic signed [COORD_WIDTH-1:0]        value,
   input  logic [fahb_pkg::BINS_REG_W-1:0]      bins_raw,
   output fahb_pkg::lane_result_type            result
);

   localparam int Edges  = MAX_BINS_PER_AXIS + 1;
   localparam int CountW = $clog2(Edges);
   localparam int IdxW   = fahb_pkg::AXIS_IDX_W;

   logic [CountW-1:0]            bins_used;
   logic [Edges-1:0]             above;
   logic [Edges-1:0]             at_or_below;
   logic [MAX_BINS_PER_AXIS-1:0] match;
   logic                         at_low;
   logic                         in_range;

   always_comb begin
      priority if (bins_raw == '0) begin
         bins_used = CountW'(1);
      end else if (32'(bins_raw) > 32'(MAX_BINS_PER_AXIS)) begin
         bins_used = CountW'(MAX_BINS_PER_AXIS);
      end else begin
         bins_used = CountW'(bins_raw);
      end
   end

   always_comb begin
      for (int i = 0; i < Edges; i++) begin
         above[i]       = value > edges[i];
         at_or_below[i] = value <= edges[i];
      end
      for (int i = 0; i < MAX_BINS_PER_AXIS; i++) begin
         match[i] = above[i] & at_or_below[i+1] & (CountW'(i) < bins_used);
      end
   end

   assign at_low   = value == edges[0];
   assign in_range = (above[0] | at_low) & at_or_below[bins_used];

   always_comb begin
      result.bin = '0;
      for (int i = MAX_BINS_PER_AXIS - 1; i >= 0; i--) begin
         if (match[i]) begin
            result.bin = IdxW'(i);
         end
      end
      if (at_low) begin
         result.bin = '0;
      end
      result.hit = in_range & (at_low | (|match));
   end

endmodule

@@ hw/rtl/fahb_merge.sv @@
// fahb_merge: combines the four lane results into one packed bin address
// a sample counts only when every axis found a bin
// depends on fahb_pkg
module fahb_merge (
   input  fahb_pkg::lane_result_type  lanes [fahb_pkg::NUM_AXES],
   output fahb_pkg::merge_result_type merged
);

   localparam int IdxW = fahb_pkg::AXIS_IDX_W;
   localparam int Axes = fahb_pkg::NUM_AXES;

   always_comb begin
      merged.hit  = 1'b1;
      merged.addr = '0;
      for (int a = 0; a < Axes; a++) begin
         merged.hit = merged.hit & lanes[a].hit;
         merged.addr[(Axes-1-a)*IdxW +: IdxW] = lanes[a].bin;
      end
   end

endmodule

@@ hw/rtl/fahb_accum.sv @@
// fahb_accum: bin sum memory with clearing pass, registered read and saturating add
// one read and one write port; the write commits the saturated sum
// depends on fahb_pkg
module fahb_accum #(
   parameter int SUM_WIDTH = 48
) (
   input  logic                         clock,
   input  logic                         reset,
   input  fahb_pkg::acc_op_type         op,
   input  logic                         commit_add,
   output logic [SUM_WIDTH-1:0]         rd_sum,
   output logic [SUM_WIDTH-1:0]         add_sum,
   output logic                         clearing
);

   localparam int AddrW  = fahb_pkg::BIN_ADDR_W;
   localparam int Depth  = fahb_pkg::BIN_DEPTH;
   localparam int WeightW = fahb_pkg::WEIGHT_W;
   localparam int AddW   = ((SUM_WIDTH > WeightW) ? SUM_WIDTH : WeightW) + 1;

   logic [SUM_WIDTH-1:0] mem [Depth];
   logic [SUM_WIDTH-1:0] rd_data_ff;
   logic [AddrW-1:0]     addr_ff;
   logic [WeightW-1:0]   weight_ff;
   logic [AddrW-1:0]     clr_cnt_ff;
   logic                 clearing_ff;
   logic [AddW-1:0]      wide_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else if (clearing_ff) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == AddrW'(Depth - 1)) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         mem[clr_cnt_ff] <= '0;
      end else if (commit_add) begin
         mem[addr_ff] <= add_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (op.valid) begin
         rd_data_ff <= mem[op.addr];
         addr_ff    <= op.addr;
         weight_ff  <= op.weight;
      end
   end

   // saturating add of the weight onto the stored sum
   assign wide_sum = AddW'(rd_data_ff) + AddW'(weight_ff);

   always_comb begin
      if (wide_sum > AddW'({SUM_WIDTH{1'b1}})) begin
         add_sum = {SUM_WIDTH{1'b1}};
      end else begin
         add_sum = SUM_WIDTH'(wide_sum);
      end
   end

   assign rd_sum   = rd_data_ff;
   assign clearing = clearing_ff;

endmodule
